FILE: design/assert_macros.svh
// Assertion helpers used by the decoder datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PSD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("decoder assertion failed");

// Condition that must never hold outside reset.
`define PSD_NEVER(label, clk, rst, cond) \
   `PSD_ASSERT(label, clk, rst, !(cond))

`endif

FILE: design/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, codes, command/status types and scaling functions of the
// polygon stream decoder.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int VT_DEPTH   = 256;
   localparam int VT_AW      = $clog2(VT_DEPTH);
   localparam int PS_DEPTH   = 15;
   localparam int PS_AW      = $clog2(PS_DEPTH + 1);
   // The block size must be a power of two.
   localparam int BLOCK_SIZE = 65536;
   localparam logic [15:0] BLOCK_MASK = 16'(BLOCK_SIZE - 1);

   localparam logic [7:0] CODE_EOF  = 8'hff;
   localparam logic [7:0] CODE_SKIP = 8'hfe;
   localparam logic [7:0] CODE_EOS  = 8'hfd;

   localparam logic [1:0] KIND_TRI = 2'd0;
   localparam logic [1:0] KIND_PAL = 2'd1;
   localparam logic [1:0] KIND_EOF = 2'd2;
   localparam logic [1:0] KIND_EOS = 2'd3;

   localparam logic [8:0] SCREEN_X_MAX = 9'd319;
   localparam logic [8:0] SCREEN_Y_MAX = 9'd239;

   typedef enum logic [2:0] {
      OUT_PAL,
      OUT_CLR0,
      OUT_CLR1,
      OUT_EOF,
      OUT_EOS,
      OUT_TRI
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      logic        flags_load;
      logic        held_load;
      logic        mask_load;
      logic        bitpos_load;
      logic        bitpos_full;
      logic        vcount_load;
      logic        vt_write;
      logic        poly_load;
      logic        vstore;
      logic        vstore_table;
      logic        addr_clr;
      logic        fan_clr;
      logic        fan_inc;
      logic        cap_a;
      logic        cap_prev;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic [2:0] flags;
      logic       full_found;
      logic       next_found;
      logic       vrem_last;
      logic       vdone;
      logic       size_ge3;
      logic       block_zero;
      logic       out_free;
      logic       fan_last;
   } status_type;

   // x * 125 / 100 is x * 5 / 4.
   function automatic logic [8:0] scale_x(input logic [7:0] v);
      logic [10:0] t;
      t = 11'(v) * 11'd5;
      return t[10:2];
   endfunction

   // y * 120 / 100 is y * 6 / 5; the division by five is a reciprocal multiply,
   // exact for the products that an 8-bit y gives.
   function automatic logic [8:0] scale_y(input logic [7:0] v);
      logic [10:0] t;
      logic [24:0] p;
      t = 11'(v) * 11'd6;
      p = 25'(t) * 25'd13108;
      return p[24:16];
   endfunction

endpackage

FILE: design/psd_ram.sv
// ----------------------------------------------------------------------------
// psd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module psd_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Parse controller: tracks the stream phase and sequences the datapath.
// ----------------------------------------------------------------------------
module psd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  psd_pkg::status_type status,
   output psd_pkg::cmd_type    cmd
);
   import psd_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_FINISH, S_PAL, S_CLR0, S_CLR1, S_MARK,
      S_FAN_A, S_FAN_B, S_FAN_C, S_FAN_EMIT, S_FAN_FETCH
   } state_type;

   typedef enum logic [3:0] {
      PH_FLAGS, PH_MASK_HI, PH_MASK_LO, PH_PAL_HI, PH_PAL_LO, PH_VCOUNT,
      PH_VX, PH_VY, PH_DESC, PH_PIDX, PH_PX, PH_PY, PH_SKIP
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      mark_eos_ff, mark_eos_in;

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         phase_ff    <= PH_FLAGS;
         mark_eos_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         mark_eos_ff <= mark_eos_in;
      end
   end

   always_comb begin
      logic [7:0] b;
      b           = status.stream_byte;
      state_in    = state_ff;
      phase_in    = phase_ff;
      mark_eos_in = mark_eos_ff;
      cmd         = '0;
      cmd.out_sel = OUT_TRI;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            unique case (phase_ff)
               PH_FLAGS: begin
                  cmd.flags_load = 1'b1;
                  if (b[1]) phase_in = PH_MASK_HI;
                  else state_in = S_FINISH;
               end
               PH_MASK_HI: begin
                  cmd.held_load = 1'b1;
                  phase_in      = PH_MASK_LO;
               end
               PH_MASK_LO: begin
                  cmd.mask_load = 1'b1;
                  if (status.full_found) begin
                     cmd.bitpos_load = 1'b1;
                     cmd.bitpos_full = 1'b1;
                     phase_in        = PH_PAL_HI;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               PH_PAL_HI: begin
                  cmd.held_load = 1'b1;
                  phase_in      = PH_PAL_LO;
               end
               PH_PAL_LO: state_in = S_PAL;
               PH_VCOUNT: begin
                  cmd.vcount_load = 1'b1;
                  phase_in        = (b != 8'd0) ? PH_VX : PH_DESC;
               end
               PH_VX: begin
                  cmd.held_load = 1'b1;
                  phase_in      = PH_VY;
               end
               PH_VY: begin
                  cmd.vt_write = 1'b1;
                  phase_in     = status.vrem_last ? PH_DESC : PH_VX;
               end
               PH_DESC: begin
                  priority if (b == CODE_EOF) begin
                     mark_eos_in = 1'b0;
                     phase_in    = PH_FLAGS;
                     state_in    = S_MARK;
                  end else if (b == CODE_SKIP) begin
                     mark_eos_in = 1'b0;
                     phase_in    = status.block_zero ? PH_FLAGS : PH_SKIP;
                     state_in    = S_MARK;
                  end else if (b == CODE_EOS) begin
                     mark_eos_in  = 1'b1;
                     cmd.addr_clr = 1'b1;
                     phase_in     = PH_FLAGS;
                     state_in     = S_MARK;
                  end else begin
                     cmd.poly_load = 1'b1;
                     if (b[3:0] != 4'd0) begin
                        phase_in = status.flags[2] ? PH_PIDX : PH_PX;
                     end
                  end
               end
               PH_PIDX, PH_PY: begin
                  cmd.vstore       = 1'b1;
                  cmd.vstore_table = (phase_ff == PH_PIDX);
                  if (phase_ff == PH_PY) phase_in = PH_PX;
                  if (status.vdone) begin
                     phase_in = PH_DESC;
                     if (status.size_ge3) begin
                        cmd.fan_clr = 1'b1;
                        state_in    = S_FAN_A;
                     end
                  end
               end
               PH_PX: begin
                  cmd.held_load = 1'b1;
                  phase_in      = PH_PY;
               end
               PH_SKIP: begin
                  if (status.block_zero) phase_in = PH_FLAGS;
               end
               default: phase_in = PH_FLAGS;
            endcase
         end
         S_FINISH: begin
            phase_in = status.flags[2] ? PH_VCOUNT : PH_DESC;
            state_in = status.flags[0] ? S_CLR0 : S_IDLE;
         end
         S_PAL: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_PAL;
               cmd.out_last = status.next_found || !status.flags[0];
               if (status.next_found) begin
                  cmd.bitpos_load = 1'b1;
                  phase_in        = PH_PAL_HI;
                  state_in        = S_IDLE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_CLR0: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_CLR0;
               state_in     = S_CLR1;
            end
         end
         S_CLR1: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_CLR1;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_MARK: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = mark_eos_ff ? OUT_EOS : OUT_EOF;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         // The polygon store has a registered read, so its data arrives in the cycle
         // after the fan index.
         S_FAN_A: begin
            cmd.fan_inc = 1'b1;
            state_in    = S_FAN_B;
         end
         S_FAN_B: begin
            cmd.cap_a   = 1'b1;
            cmd.fan_inc = 1'b1;
            state_in    = S_FAN_C;
         end
         S_FAN_C: begin
            cmd.cap_prev = 1'b1;
            state_in     = S_FAN_EMIT;
         end
         S_FAN_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_TRI;
               cmd.out_last = status.fan_last;
               cmd.cap_prev = 1'b1;
               cmd.fan_inc  = 1'b1;
               state_in     = status.fan_last ? S_IDLE : S_FAN_FETCH;
            end
         end
         S_FAN_FETCH: state_in = S_FAN_EMIT;
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: design/psd_datapath.sv
// ----------------------------------------------------------------------------
// psd_datapath
// Decoder datapath: stream registers, vertex table, polygon store and the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_stream_byte,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   input  psd_pkg::cmd_type    cmd,
   output psd_pkg::status_type status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [1:0]          rsp_kind,
   output logic [8:0]          rsp_ax,
   output logic [8:0]          rsp_ay,
   output logic [8:0]          rsp_bx,
   output logic [8:0]          rsp_by_coord,
   output logic [8:0]          rsp_cx,
   output logic [8:0]          rsp_cy,
   output logic [3:0]          rsp_colour,
   output logic [3:0]          rsp_red,
   output logic [3:0]          rsp_green,
   output logic [3:0]          rsp_blue,
   output logic                rsp_last
);
   import psd_pkg::*;

   logic [7:0]          byte_ff;
   logic [15:0]         addr_ff;
   logic [2:0]          flags_ff;
   logic [7:0]          held_ff;
   logic [15:0]         mask_ff;
   logic [3:0]          bitpos_ff;
   logic [7:0]          vrem_ff;
   logic [7:0]          widx_ff;
   logic [3:0]          size_ff;
   logic [3:0]          colour_ff;
   logic [PS_AW-1:0]    count_ff;
   logic [PS_AW-1:0]    fan_idx_ff;
   logic [17:0]         a_ff;
   logic [17:0]         prev_ff;
   logic                flip_ff;
   logic [VT_DEPTH-1:0] vt_valid_ff;
   logic                vt_hit_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_kind_ff;
   logic [8:0]          rsp_ax_ff, rsp_ay_ff, rsp_bx_ff, rsp_by_ff, rsp_cx_ff, rsp_cy_ff;
   logic [3:0]          rsp_colour_ff, rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                rsp_last_ff;

   logic [17:0]         vt_rdata, ps_rdata, scaled, vstore_data, tri_p, tri_q;
   logic                vt_wr_en, ps_wr_en, vt_in_range, rd_in_range, out_free;
   logic [15:0]         full_mask, next_mask;
   logic [3:0]          full_pos, next_pos;
   logic [PS_AW-1:0]    count_inc, fan_inc_val;

   function automatic logic [3:0] top_bit(input logic [15:0] v);
      logic [3:0] pos;
      pos = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) pos = 4'(i);
      end
      return pos;
   endfunction

   assign scaled      = {scale_x(held_ff), scale_y(byte_ff)};
   assign vt_in_range = ({1'b0, widx_ff} < 9'(VT_DEPTH));
   assign rd_in_range = ({1'b0, req_stream_byte} < 9'(VT_DEPTH));
   assign vt_wr_en    = cmd.vt_write && vt_in_range;
   assign ps_wr_en    = cmd.vstore && (count_ff < PS_AW'(PS_DEPTH));
   assign vstore_data = cmd.vstore_table ? (vt_hit_ff ? vt_rdata : 18'd0) : scaled;
   assign full_mask   = {held_ff, byte_ff};
   assign next_mask   = mask_ff & ((16'd1 << bitpos_ff) - 16'd1);
   assign full_pos    = top_bit(full_mask);
   assign next_pos    = top_bit(next_mask);
   assign count_inc   = count_ff + PS_AW'(1);
   assign fan_inc_val = fan_idx_ff + PS_AW'(1);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign tri_p       = flip_ff ? ps_rdata : prev_ff;
   assign tri_q       = flip_ff ? prev_ff : ps_rdata;

   psd_ram #(.WIDTH(18), .DEPTH(VT_DEPTH)) u_vertex_table (
      .clock   (clock),
      .wr_en   (vt_wr_en),
      .wr_addr (widx_ff[VT_AW-1:0]),
      .wr_data (scaled),
      .rd_addr (req_stream_byte[VT_AW-1:0]),
      .rd_data (vt_rdata)
   );

   psd_ram #(.WIDTH(18), .DEPTH(PS_DEPTH)) u_polygon_store (
      .clock   (clock),
      .wr_en   (ps_wr_en),
      .wr_addr (count_ff),
      .wr_data (vstore_data),
      .rd_addr (fan_idx_ff),
      .rd_data (ps_rdata)
   );

   always_comb begin
      status             = '0;
      status.stream_byte = byte_ff;
      status.flags       = flags_ff;
      status.full_found  = (full_mask != 16'd0);
      status.next_found  = (next_mask != 16'd0);
      status.vrem_last   = (vrem_ff == 8'd1);
      status.vdone       = ({1'b0, count_inc} >= {1'b0, size_ff});
      status.size_ge3    = (size_ff >= 4'd3);
      status.block_zero  = ((addr_ff & BLOCK_MASK) == 16'd0);
      status.out_free    = out_free;
      status.fan_last    = ({1'b0, fan_inc_val} == {1'b0, size_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= 16'd0;
         flags_ff     <= 3'd0;
         held_ff      <= 8'd0;
         mask_ff      <= 16'd0;
         bitpos_ff    <= 4'd15;
         vrem_ff      <= 8'd0;
         widx_ff      <= 8'd0;
         size_ff      <= 4'd0;
         colour_ff    <= 4'd0;
         count_ff     <= '0;
         fan_idx_ff   <= '0;
         flip_ff      <= 1'b0;
         vt_valid_ff  <= '0;
         vt_hit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) flip_ff <= csr_write_data;
         vt_hit_ff <= rd_in_range && vt_valid_ff[req_stream_byte[VT_AW-1:0]];
         if (cmd.accept) begin
            byte_ff <= req_stream_byte;
            addr_ff <= addr_ff + 16'd1;
         end
         if (cmd.addr_clr) addr_ff <= 16'd0;
         if (cmd.flags_load) flags_ff <= byte_ff[2:0];
         if (cmd.held_load) held_ff <= byte_ff;
         if (cmd.mask_load) mask_ff <= full_mask;
         if (cmd.bitpos_load) bitpos_ff <= cmd.bitpos_full ? full_pos : next_pos;
         if (cmd.vcount_load) begin
            vrem_ff <= byte_ff;
            widx_ff <= 8'd0;
         end
         if (cmd.vt_write) begin
            vrem_ff <= vrem_ff - 8'd1;
            widx_ff <= widx_ff + 8'd1;
            if (vt_in_range) vt_valid_ff[widx_ff[VT_AW-1:0]] <= 1'b1;
         end
         if (cmd.poly_load) begin
            size_ff   <= byte_ff[3:0];
            colour_ff <= byte_ff[7:4];
            count_ff  <= '0;
         end
         if (cmd.vstore) count_ff <= count_inc;
         if (cmd.fan_clr) fan_idx_ff <= '0;
         if (cmd.fan_inc) fan_idx_ff <= fan_inc_val;
         if (cmd.out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) a_ff <= ps_rdata;
      if (cmd.cap_prev) prev_ff <= ps_rdata;
      if (cmd.out_load) begin
         rsp_last_ff   <= cmd.out_last;
         rsp_kind_ff   <= KIND_TRI;
         rsp_ax_ff     <= 9'd0;
         rsp_ay_ff     <= 9'd0;
         rsp_bx_ff     <= 9'd0;
         rsp_by_ff     <= 9'd0;
         rsp_cx_ff     <= 9'd0;
         rsp_cy_ff     <= 9'd0;
         rsp_colour_ff <= 4'd0;
         rsp_red_ff    <= 4'd0;
         rsp_green_ff  <= 4'd0;
         rsp_blue_ff   <= 4'd0;
         unique case (cmd.out_sel)
            OUT_PAL: begin
               rsp_kind_ff   <= KIND_PAL;
               rsp_colour_ff <= 4'd15 - bitpos_ff;
               rsp_red_ff    <= {held_ff[2:0], 1'b0};
               rsp_green_ff  <= {byte_ff[6:4], 1'b0};
               rsp_blue_ff   <= {byte_ff[2:0], 1'b0};
            end
            OUT_CLR0: begin
               rsp_bx_ff <= SCREEN_X_MAX;
               rsp_by_ff <= SCREEN_Y_MAX;
               rsp_cx_ff <= SCREEN_X_MAX;
            end
            OUT_CLR1: begin
               rsp_ax_ff <= SCREEN_X_MAX;
               rsp_ay_ff <= SCREEN_Y_MAX;
               rsp_cy_ff <= SCREEN_Y_MAX;
            end
            OUT_EOF: rsp_kind_ff <= KIND_EOF;
            OUT_EOS: rsp_kind_ff <= KIND_EOS;
            OUT_TRI: begin
               rsp_ax_ff     <= a_ff[17:9];
               rsp_ay_ff     <= a_ff[8:0];
               rsp_bx_ff     <= tri_p[17:9];
               rsp_by_ff     <= tri_p[8:0];
               rsp_cx_ff     <= tri_q[17:9];
               rsp_cy_ff     <= tri_q[8:0];
               rsp_colour_ff <= colour_ff;
            end
            default: rsp_kind_ff <= KIND_TRI;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_ax       = rsp_ax_ff;
   assign rsp_ay       = rsp_ay_ff;
   assign rsp_bx       = rsp_bx_ff;
   assign rsp_by_coord = rsp_by_ff;
   assign rsp_cx       = rsp_cx_ff;
   assign rsp_cy       = rsp_cy_ff;
   assign rsp_colour   = rsp_colour_ff;
   assign rsp_red      = rsp_red_ff;
   assign rsp_green    = rsp_green_ff;
   assign rsp_blue     = rsp_blue_ff;
   assign rsp_last     = rsp_last_ff;

   `PSD_NEVER(a_no_overwrite, clock, reset, cmd.out_load && !out_free)
   `PSD_ASSERT(a_fan_bound, clock, reset, cmd.fan_inc |-> ({1'b0, fan_idx_ff} < {1'b0, size_ff}))
   `PSD_ASSERT(a_tri_range, clock, reset, (rsp_valid_ff && rsp_kind_ff == KIND_TRI) |-> (rsp_ax_ff <= SCREEN_X_MAX && rsp_cy_ff <= 9'd306))

endmodule

FILE: design/polygon_stream_decoder.sv
// ----------------------------------------------------------------------------
// polygon_stream_decoder
// Byte-serial decoder of an indexed polygon animation stream into palette
// writes, clear triangles, triangle fans and frame markers.
// ----------------------------------------------------------------------------
// One stream byte is taken per transaction and handled to completion before
// the next is taken. A byte that causes no result passes accept and decode,
// and a finish state too when it closes the palette part of a frame header;
// a clear adds a state for each of its two triangles. A palette word adds a
// palette state, and the finish state if it is the last of the palette; a
// frame marker adds a marker state. The vertex byte that closes a polygon of
// n >= 3 vertices passes accept and decode, primes the fan walk through the
// single read port of the polygon store with its registered read, emits the
// first triangle, and fetches and emits each further one. Stalls on the
// result channel hold each result state. The 256-entry vertex table reads as
// zero after reset by per-entry valid flags, so no clearing pass is needed.
module polygon_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [8:0] rsp_ax,
   output logic [8:0] rsp_ay,
   output logic [8:0] rsp_bx,
   output logic [8:0] rsp_by_coord,
   output logic [8:0] rsp_cx,
   output logic [8:0] rsp_cy,
   output logic [3:0] rsp_colour,
   output logic [3:0] rsp_red,
   output logic [3:0] rsp_green,
   output logic [3:0] rsp_blue,
   output logic       rsp_last
);
   import psd_pkg::*;

   cmd_type    cmd;
   status_type status;

   psd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   psd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_stream_byte  (req_stream_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_kind         (rsp_kind),
      .rsp_ax           (rsp_ax),
      .rsp_ay           (rsp_ay),
      .rsp_bx           (rsp_bx),
      .rsp_by_coord     (rsp_by_coord),
      .rsp_cx           (rsp_cx),
      .rsp_cy           (rsp_cy),
      .rsp_colour       (rsp_colour),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_last         (rsp_last)
   );

endmodule

FILE: tb/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Watches the stream and result channels of the polygon stream decoder,
// predicts the results of every accepted byte and compares each whole result.
// ----------------------------------------------------------------------------
module psd_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_stream_byte,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_kind,
   input  logic [8:0] rsp_ax,
   input  logic [8:0] rsp_ay,
   input  logic [8:0] rsp_bx,
   input  logic [8:0] rsp_by_coord,
   input  logic [8:0] rsp_cx,
   input  logic [8:0] rsp_cy,
   input  logic [3:0] rsp_colour,
   input  logic [3:0] rsp_red,
   input  logic [3:0] rsp_green,
   input  logic [3:0] rsp_blue,
   input  logic       rsp_last,
   output int         fail_count,
   output int         pending_count
);
   import psd_pkg::*;

   typedef enum logic [3:0] {
      P_FLAGS, P_MASK_HI, P_MASK_LO, P_PAL_HI, P_PAL_LO, P_VCOUNT, P_VX, P_VY,
      P_DESC, P_PIDX, P_PX, P_PY, P_SKIP
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [8:0] ax, ay, bx, by_coord, cx, cy;
      logic [3:0] colour, red, green, blue;
      logic       last;
   } draw_type;

   draw_type   draw_queue[$];
   draw_type   byte_results[$];
   logic       flip;
   phase_type  phase;
   logic [2:0] mode;
   logic [15:0] addr;
   logic [15:0] pal_mask;
   logic [3:0] bit_pos;
   logic [7:0] held;
   logic [7:0] vert_left;
   logic [7:0] vert_idx;
   logic [8:0] tab_x[256];
   logic [8:0] tab_y[256];
   logic [17:0] poly_v[15];
   logic [3:0] poly_n;
   logic [3:0] poly_hue;
   logic [3:0] poly_cnt;

   function automatic logic [8:0] mul_x(logic [7:0] v);
      int t;
      t = int'(v) * 125 / 100;
      return t[8:0];
   endfunction

   function automatic logic [8:0] mul_y(logic [7:0] v);
      int t;
      t = int'(v) * 120 / 100;
      return t[8:0];
   endfunction

   task automatic emit(logic [1:0] k, logic [8:0] ax, ay, bx, by, cx, cy,
                       logic [3:0] col, r, g, b);
      draw_type d;
      d = '{k, ax, ay, bx, by, cx, cy, col, r, g, b, 1'b0};
      byte_results.push_back(d);
   endtask

   task automatic end_palette();
      if (mode[0]) begin
         emit(KIND_TRI, 0, 0, SCREEN_X_MAX, SCREEN_Y_MAX, SCREEN_X_MAX, 0, 0, 0, 0, 0);
         emit(KIND_TRI, SCREEN_X_MAX, SCREEN_Y_MAX, 0, 0, 0, SCREEN_Y_MAX, 0, 0, 0, 0);
      end
      phase = mode[2] ? P_VCOUNT : P_DESC;
   endtask

   task automatic next_colour(int from);
      int b;
      b = from;
      while (b >= 0 && !pal_mask[b]) b--;
      if (b < 0) end_palette();
      else begin
         bit_pos = 4'(b);
         phase = P_PAL_HI;
      end
   endtask

   task automatic add_vertex(logic [8:0] x, logic [8:0] y);
      int m;
      logic [17:0] a, p, q, t;
      if (poly_cnt < 15) poly_v[poly_cnt] = {x, y};
      poly_cnt = poly_cnt + 1;
      if (poly_cnt < poly_n) return;
      phase = P_DESC;
      m = (poly_n < 15) ? poly_n : 15;
      for (int i = 0; i + 2 < m; i++) begin
         a = poly_v[0];
         p = poly_v[i + 1];
         q = poly_v[i + 2];
         if (flip) begin
            t = p;
            p = q;
            q = t;
         end
         emit(KIND_TRI, a[17:9], a[8:0], p[17:9], p[8:0], q[17:9], q[8:0],
              poly_hue, 0, 0, 0);
      end
   endtask

   task automatic decode_byte(logic [7:0] v);
      logic [15:0] rgb;
      addr = addr + 1;
      case (phase)
         P_MASK_HI: begin
            held = v;
            phase = P_MASK_LO;
         end
         P_MASK_LO: begin
            pal_mask = {held, v};
            next_colour(15);
         end
         P_PAL_HI: begin
            held = v;
            phase = P_PAL_LO;
         end
         P_PAL_LO: begin
            rgb = {held, v};
            emit(KIND_PAL, 0, 0, 0, 0, 0, 0, 4'd15 - bit_pos,
                 {rgb[10:8], 1'b0}, {rgb[6:4], 1'b0}, {rgb[2:0], 1'b0});
            next_colour(int'(bit_pos) - 1);
         end
         P_VCOUNT: begin
            vert_left = v;
            vert_idx = 0;
            phase = (v != 0) ? P_VX : P_DESC;
         end
         P_VX: begin
            held = v;
            phase = P_VY;
         end
         P_VY: begin
            tab_x[vert_idx] = mul_x(held);
            tab_y[vert_idx] = mul_y(v);
            vert_idx = vert_idx + 1;
            vert_left = vert_left - 1;
            phase = (vert_left != 0) ? P_VX : P_DESC;
         end
         P_DESC: begin
            if (v == CODE_EOF) begin
               emit(KIND_EOF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
               phase = P_FLAGS;
            end else if (v == CODE_SKIP) begin
               emit(KIND_EOF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
               phase = ((addr & BLOCK_MASK) == 0) ? P_FLAGS : P_SKIP;
            end else if (v == CODE_EOS) begin
               emit(KIND_EOS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
               addr = 0;
               phase = P_FLAGS;
            end else begin
               poly_n = v[3:0];
               poly_hue = v[7:4];
               poly_cnt = 0;
               if (poly_n != 0) phase = mode[2] ? P_PIDX : P_PX;
            end
         end
         P_PIDX: add_vertex(tab_x[v], tab_y[v]);
         P_PX: begin
            held = v;
            phase = P_PY;
         end
         P_PY: begin
            phase = P_PX;
            add_vertex(mul_x(held), mul_y(v));
         end
         P_SKIP: if ((addr & BLOCK_MASK) == 0) phase = P_FLAGS;
         default: begin
            mode = v[2:0];
            if (mode[1]) phase = P_MASK_HI;
            else end_palette();
         end
      endcase
      if (byte_results.size() > 0) byte_results[$].last = 1'b1;
      while (byte_results.size() > 0) draw_queue.push_back(byte_results.pop_front());
   endtask

   always @(posedge clock) begin
      draw_type want, got;
      if (reset) begin
         flip <= 1'b0;
         phase = P_FLAGS;
         mode = 0;
         addr = 0;
         pal_mask = 0;
         bit_pos = 4'd15;
         held = 0;
         vert_left = 0;
         vert_idx = 0;
         poly_n = 0;
         poly_hue = 0;
         poly_cnt = 0;
         for (int i = 0; i < 256; i++) begin
            tab_x[i] = 0;
            tab_y[i] = 0;
         end
         for (int i = 0; i < 15; i++) poly_v[i] = 0;
         draw_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_write_enable) flip <= csr_write_data;
         if (req_valid && req_ready) decode_byte(req_stream_byte);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_ax, rsp_ay, rsp_bx, rsp_by_coord, rsp_cx, rsp_cy,
                    rsp_colour, rsp_red, rsp_green, rsp_blue, rsp_last};
            if (draw_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = draw_queue.pop_front();
               if (want !== got) begin
                  $display("%0t: result mismatch expected %h actual %h", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= draw_queue.size();
   end

endmodule

FILE: tb/tb_polygon_stream_decoder.sv
// ----------------------------------------------------------------------------
// tb_polygon_stream_decoder
// Drives frames of palette, vertex table, polygon and marker bytes into the
// decoder under random idling and a long receiver hold-off, switching the
// winding register between phases; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_polygon_stream_decoder;
   import psd_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_stream_byte = 8'd0;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [8:0] rsp_ax, rsp_ay, rsp_bx, rsp_by_coord, rsp_cx, rsp_cy;
   logic [3:0] rsp_colour, rsp_red, rsp_green, rsp_blue;
   logic       rsp_last;
   int         fail_count;
   int         pending_count;
   int         idle_pct = 36;
   logic       hold_off = 1'b0;
   logic       hold_done = 1'b0;
   logic       flip_done = 1'b0;
   logic       unflip_done = 1'b0;
   int         quiet_cycles = 0;
   int         byte_total = 0;
   logic [7:0] byte_list[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   polygon_stream_decoder dut (.*);

   psd_checker u_checker (.*);

   // Receiver: random stalls, with one long hold-off on request.
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_byte(logic [7:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      byte_total++;
   endtask

   task automatic flush_list();
      while (byte_list.size() > 0) send_byte(byte_list.pop_front());
      req_valid <= 1'b0;
   endtask

   task automatic set_winding(logic v);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Builds one well-formed frame with random content into byte_list.
   task automatic build_frame(logic [7:0] last_code);
      logic [7:0] flags;
      logic [15:0] mask;
      int nv, np, cnt;
      flags = 8'($urandom);
      byte_list.push_back(flags);
      if (flags[1]) begin
         mask = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
         byte_list.push_back(mask[15:8]);
         byte_list.push_back(mask[7:0]);
         for (int i = 0; i < 16; i++)
            if (mask[i]) begin
               byte_list.push_back(8'($urandom));
               byte_list.push_back(8'($urandom));
            end
      end
      if (flags[2]) begin
         nv = $urandom_range(6);
         byte_list.push_back(8'(nv));
         repeat (2 * nv) byte_list.push_back(8'($urandom));
      end
      np = $urandom_range(4);
      repeat (np) begin
         cnt = ($urandom_range(9) == 0) ? 15 : $urandom_range(6);
         // Colour 15 is kept out so that a descriptor never looks like a marker.
         byte_list.push_back({4'($urandom_range(14)), 4'(cnt)});
         repeat (flags[2] ? cnt : 2 * cnt) byte_list.push_back(8'($urandom));
      end
      byte_list.push_back(last_code);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_winding(1'b1);

      // Directed: palette with clear, vertex table with extremes, indexed and
      // direct fans including one of fifteen, short polygons, and the EOS and EOF markers.
      byte_list = '{8'h07, 8'h80, 8'h01, 8'h07, 8'h77, 8'h00, 8'h00,
                    8'd2, 8'hff, 8'hff, 8'h00, 8'h00,
                    8'h53, 8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'hfd};
      flush_list();
      byte_list = '{8'hf8, 8'h3f};
      for (int i = 0; i < 30; i++) byte_list.push_back(8'($urandom));
      byte_list.push_back(8'h02);
      byte_list.push_back(8'h10);
      byte_list.push_back(8'h81);
      byte_list.push_back(8'h00);
      byte_list.push_back(8'h82);
      byte_list.push_back(8'h00);
      byte_list.push_back(8'hff);
      flush_list();
      set_winding(1'b0);

      // Random frames; one frame runs under a long receiver hold-off.
      while (byte_total < 440) begin
         if ($urandom_range(15) == 0) byte_list.push_back(8'($urandom));
         if ($urandom_range(9) == 0) build_frame(CODE_EOS);
         else build_frame(CODE_EOF);
         if (byte_total > 150 && byte_total < 280) idle_pct = 0;
         else idle_pct = 36;
         if (!hold_done && byte_total > 300) begin
            hold_done = 1'b1;
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (300) @(posedge clock);
                  hold_off <= 1'b0;
               end
               flush_list();
            join
         end else flush_list();
         if (!flip_done && byte_total > 240) begin
            flip_done = 1'b1;
            set_winding(1'b1);
         end
         if (!unflip_done && byte_total > 380) begin
            unflip_done = 1'b1;
            set_winding(1'b0);
         end
      end
      // A skip drops the rest of the block, so it closes the run.
      build_frame(CODE_SKIP);
      repeat (8) byte_list.push_back(8'($urandom));
      flush_list();
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/psd_pkg.sv
design/psd_ram.sv
design/psd_ctrl.sv
design/psd_datapath.sv
design/polygon_stream_decoder.sv
tb/psd_checker.sv
tb/tb_polygon_stream_decoder.sv
